// ===== rtl/svt_pkg.sv =====
package svt_pkg;

	localparam int TABLE_ENTRIES  = 21;
	localparam int STORED_ENTRIES = 21;
	localparam int USED_ENTRIES   = (TABLE_ENTRIES < STORED_ENTRIES) ? TABLE_ENTRIES
	                                                                 : STORED_ENTRIES;
	localparam int IDX_W          = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;

	localparam int VOLT_W         = 22;
	localparam int SLOPE_W        = 13;
	localparam int SCALE          = 100;
	localparam int SCALE_W        = 7;
	localparam int NUM_W          = VOLT_W + SCALE_W;
	localparam int REM_W          = SLOPE_W + 1;
	localparam int CNT_W          = $clog2(NUM_W);
	localparam int TEMP_W         = 15;
	localparam int CALC_W         = 16;
	localparam int BASE_STEP      = 1000;
	localparam int BASE_OFFSET    = 5000;

	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

	// sensor voltage at -50 C, -40 C, ... 150 C, descending
	localparam logic [VOLT_W-1:0] VOLT_TAB [STORED_ENTRIES] = '{
		22'd1350441, 22'd1300593, 22'd1250398, 22'd1199884, 22'd1149070,
		22'd1097987, 22'd1046647, 22'd995050,  22'd943227,  22'd891178,
		22'd838882,  22'd786360,  22'd733608,  22'd680654,  22'd627490,
		22'd574117,  22'd520551,  22'd466760,  22'd412739,  22'd358164,
		22'd302785
	};

	// band slope in uV per degree
	localparam logic [SLOPE_W-1:0] SLOPE_TAB [STORED_ENTRIES] = '{
		13'd4985, 13'd5020, 13'd5051, 13'd5081, 13'd5108,
		13'd5134, 13'd5160, 13'd5182, 13'd5205, 13'd5230,
		13'd5252, 13'd5275, 13'd5295, 13'd5316, 13'd5337,
		13'd5357, 13'd5379, 13'd5402, 13'd5458, 13'd5538,
		13'd5538
	};

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_SEARCH,
		FE_PUSH
	} svt_fe_state_t;

	typedef enum logic [1:0] {
		BE_IDLE,
		BE_DIV,
		BE_FINISH
	} svt_be_state_t;

	typedef struct packed {
		logic              oor;
		logic [IDX_W-1:0]  idx;
		logic [VOLT_W-1:0] d;
	} svt_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} svt_q_status_t;

	// band base temperature times 100
	function automatic logic signed [CALC_W-1:0] base_of(input logic [IDX_W-1:0] idx);
		logic signed [CALC_W-1:0] i_s;
		i_s = $signed(CALC_W'(idx));
		return CALC_W'(i_s * CALC_W'(BASE_STEP)) - CALC_W'(BASE_OFFSET);
	endfunction

endpackage

// ===== rtl/svt_front.sv =====
module svt_front import svt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [VOLT_W-1:0]   voltage_uv,
	input  svt_q_status_t       q_status,
	output logic                busy,
	output logic                push,
	output svt_item_t           item
);

	svt_fe_state_t      state_q, state_d;
	logic [VOLT_W-1:0]  v_q;
	logic               oor_q;
	logic [IDX_W-1:0]   lo_q, hi_q;
	logic [IDX_W:0]     mid_sum;
	logic [IDX_W-1:0]   mid;
	logic               accept;
	logic               in_span;
	logic               mid_ok;

	assign in_span = (voltage_uv <= VOLT_TAB[0]) && (voltage_uv >= VOLT_TAB[USED_ENTRIES-1]);
	assign mid_sum = (IDX_W+1)'(lo_q) + (IDX_W+1)'(hi_q) + (IDX_W+1)'(1);
	assign mid     = mid_sum[IDX_W:1];
	assign mid_ok  = VOLT_TAB[mid] >= v_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FE_IDLE: begin
				if (start) begin
					state_d = in_span ? FE_SEARCH : FE_PUSH;
				end
			end
			FE_SEARCH: begin
				if (lo_q == hi_q) begin
					state_d = FE_PUSH;
				end
			end
			FE_PUSH: begin
				if (!q_status.full) begin
					state_d = FE_IDLE;
				end
			end
			default: state_d = FE_IDLE;
		endcase
	end

	always_comb begin
		busy   = (state_q != FE_IDLE);
		accept = (state_q == FE_IDLE) && start;
		push   = (state_q == FE_PUSH) && !q_status.full;
		item.oor = oor_q;
		item.idx = lo_q;
		item.d   = VOLT_TAB[lo_q] - v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// binary search: lo always points at an entry not below the voltage
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q   <= voltage_uv;
			oor_q <= !in_span;
			lo_q  <= '0;
			hi_q  <= IDX_W'(USED_ENTRIES - 1);
		end else if (state_q == FE_SEARCH && lo_q != hi_q) begin
			if (mid_ok) begin
				lo_q <= mid;
			end else begin
				hi_q <= mid - IDX_W'(1);
			end
		end
	end

endmodule

// ===== rtl/svt_queue.sv =====
module svt_queue import svt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  svt_item_t     wr_item,
	input  logic          pop,
	output svt_item_t     rd_item,
	output svt_q_status_t status
);

	svt_item_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign status.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign rd_item      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// ===== rtl/svt_back.sv =====
module svt_back import svt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  svt_q_status_t       q_status,
	input  svt_item_t           item,
	output logic                pop,
	output logic                done,
	output logic [TEMP_W-1:0]   temp_centi,
	output logic                out_of_range
);

	svt_be_state_t            state_q, state_d;
	logic [NUM_W-1:0]         quot_q;
	logic [REM_W-1:0]         rem_q;
	logic [SLOPE_W-1:0]       div_q;
	logic signed [CALC_W-1:0] base_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     done_q;
	logic [TEMP_W-1:0]        temp_q;
	logic                     oor_q;

	logic                     load;
	logic                     emit_oor;
	logic                     emit_temp;
	logic [REM_W-1:0]         rem_sh;
	logic [REM_W-1:0]         rem_diff;
	logic                     fits;
	logic signed [CALC_W-1:0] t_sum;
	logic signed [CALC_W-1:0] t_adj;

	assign rem_sh   = {rem_q[REM_W-2:0], quot_q[NUM_W-1]};
	assign rem_diff = rem_sh - REM_W'(div_q);
	assign fits     = rem_sh >= REM_W'(div_q);

	assign t_sum = base_q + $signed(CALC_W'(quot_q[TEMP_W-1:0]));
	// negative result with a fraction rounds toward zero
	assign t_adj = (t_sum < 0 && rem_q != '0) ? t_sum + CALC_W'(1) : t_sum;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BE_IDLE: begin
				if (!q_status.empty && !item.oor) begin
					state_d = BE_DIV;
				end
			end
			BE_DIV: begin
				if (cnt_q == '0) begin
					state_d = BE_FINISH;
				end
			end
			BE_FINISH: state_d = BE_IDLE;
			default:   state_d = BE_IDLE;
		endcase
	end

	always_comb begin
		pop       = (state_q == BE_IDLE) && !q_status.empty;
		load      = pop && !item.oor;
		emit_oor  = pop && item.oor;
		emit_temp = (state_q == BE_FINISH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BE_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit_oor || emit_temp;
		end
	end

	// restoring divide, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (load) begin
			quot_q <= NUM_W'(item.d) * NUM_W'(SCALE);
			rem_q  <= '0;
			div_q  <= SLOPE_TAB[item.idx];
			base_q <= base_of(item.idx);
			cnt_q  <= CNT_W'(NUM_W - 1);
		end else if (state_q == BE_DIV) begin
			quot_q <= {quot_q[NUM_W-2:0], fits};
			rem_q  <= fits ? rem_diff : rem_sh;
			cnt_q  <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (emit_oor) begin
			temp_q <= '0;
			oor_q  <= 1'b1;
		end else if (emit_temp) begin
			temp_q <= t_adj[TEMP_W-1:0];
			oor_q  <= 1'b0;
		end
	end

	assign done         = done_q;
	assign temp_centi   = temp_q;
	assign out_of_range = oor_q;

endmodule

// ===== rtl/sensor_voltage_to_temperature.sv =====
// sensor voltage to temperature converter
//
// a voltage in microvolts is presented on voltage_uv with start; it is taken
// on a clock edge where start is high and busy is low. one result comes back
// per transfer, in order: done is high for exactly one cycle while temp_centi
// (signed, hundredths of a degree) and out_of_range are valid. the receiver
// cannot stall, so results are never held back.
//
// the front end checks the span and, for an in-range voltage, runs a binary
// search over the voltage table, one probe per cycle (four or five for 21
// entries), then hands the band index and offset to a two-entry queue. busy
// stays high from the transfer until the item is pushed, longer while the
// queue is full. the back end divides the scaled offset by the band slope
// bit-serially and takes no new item until the current one is finished, so
// that divider sets the sustained rate. out-of-range items pass the back end
// without a divide.
//
// reset clears the front state machine, the queue and the back end; any item
// in flight is dropped and done stays low until a new transfer completes.
module sensor_voltage_to_temperature import svt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [VOLT_W-1:0]   voltage_uv,
	output logic                done,
	output logic [TEMP_W-1:0]   temp_centi,
	output logic                out_of_range
);

	svt_q_status_t q_status;
	svt_item_t     wr_item;
	svt_item_t     rd_item;
	logic          push;
	logic          pop;

	svt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.voltage_uv (voltage_uv),
		.q_status   (q_status),
		.busy       (busy),
		.push       (push),
		.item       (wr_item)
	);

	svt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.status  (q_status)
	);

	svt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.item         (rd_item),
		.pop          (pop),
		.done         (done),
		.temp_centi   (temp_centi),
		.out_of_range (out_of_range)
	);

endmodule

// ===== rtl/svt_checker.sv =====
module svt_checker import svt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [VOLT_W-1:0] voltage_uv,
	input logic              done,
	input logic [TEMP_W-1:0] temp_centi,
	input logic              out_of_range
);

	// a transfer always makes the front end busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after transfer");

	// busy only rises because of a transfer
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a transfer");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_range |-> temp_centi == '0)
		else $error("out of range result not zero");

	a_temp_span: assert property (@(posedge clk) disable iff (!arst_n)
		done && !out_of_range |->
			($signed(temp_centi) >= -15'sd5000) && ($signed(temp_centi) <= 15'sd15000))
		else $error("temperature outside table span");

endmodule

bind sensor_voltage_to_temperature svt_checker u_svt_checker (.*);

// ===== dv/sensor_voltage_to_temperature_test.sv =====
module sensor_voltage_to_temperature_test;
	import svt_pkg::*;

	localparam int POINTS      = 21;
	localparam int NUM_RANDOM  = 1330;
	localparam int IDLE_PCT    = 34;
	localparam int CALM_FIRST  = 500;
	localparam int CALM_LAST   = 800;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 60;

	// sensor voltage per 10 degree step from -50 C, and band slope in uV per degree
	localparam int VOLT_POINTS [POINTS] = '{
		1350441, 1300593, 1250398, 1199884, 1149070,
		1097987, 1046647,  995050,  943227,  891178,
		 838882,  786360,  733608,  680654,  627490,
		 574117,  520551,  466760,  412739,  358164,
		 302785
	};
	localparam int BAND_SLOPES [POINTS] = '{
		4985, 5020, 5051, 5081, 5108,
		5134, 5160, 5182, 5205, 5230,
		5252, 5275, 5295, 5316, 5337,
		5357, 5379, 5402, 5458, 5538,
		5538
	};

	typedef struct {
		logic [VOLT_W-1:0] volts;
		logic [TEMP_W-1:0] temp;
		logic              oor;
	} reading_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [VOLT_W-1:0] voltage_uv = '0;
	logic              done;
	logic [TEMP_W-1:0] temp_centi;
	logic              out_of_range;

	logic [VOLT_W-1:0] volts_to_send [$];
	reading_t          temps_due [$];
	int                sent_count = 0;
	int                stall_cycles = 0;
	bit                failed = 1'b0;

	sensor_voltage_to_temperature dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.voltage_uv   (voltage_uv),
		.done         (done),
		.temp_centi   (temp_centi),
		.out_of_range (out_of_range)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic reading_t convert_voltage(input logic [VOLT_W-1:0] v);
		reading_t res;
		int       span;
		int       vi;
		int       band;
		int       offset;
		int       quot;
		int       rem;
		int       t;
		res.volts = v;
		res.temp  = '0;
		res.oor   = 1'b1;
		span = (TABLE_ENTRIES < POINTS) ? TABLE_ENTRIES : POINTS;
		vi   = int'(v);
		if (span < 1 || vi > VOLT_POINTS[0] || vi < VOLT_POINTS[span-1])
			return res;
		band = 0;
		for (int k = 0; k < span; k++) begin
			if (VOLT_POINTS[k] >= vi)
				band = k;
		end
		offset = VOLT_POINTS[band] - vi;
		quot   = (offset * 100) / BAND_SLOPES[band];
		rem    = (offset * 100) % BAND_SLOPES[band];
		t      = (band * 10 - 50) * 100 + quot;
		// below zero a leftover fraction rounds toward zero
		if (t < 0 && rem != 0)
			t = t + 1;
		res.temp = TEMP_W'(t);
		res.oor  = 1'b0;
		return res;
	endfunction

	initial begin
		int pick;
		int v;
		volts_to_send = '{
			22'd0, 22'h3FFFFF, 22'h2AAAAA, 22'h155555,
			22'd1350441, 22'd1350442, 22'd1350440,
			22'd302785, 22'd302784, 22'd302786,
			22'd1097987, 22'd1097988, 22'd1098039,
			22'd1300593, 22'd838882, 22'd838883,
			22'd358164, 22'd358163, 22'd1200000,
			22'd700000, 22'd1000000, 22'd1048576
		};
		for (int i = 0; i < NUM_RANDOM; i++) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				v = $urandom_range(VOLT_POINTS[0], VOLT_POINTS[POINTS-1]);
			end else if (pick < 80) begin
				// just around a table point
				v = VOLT_POINTS[$urandom_range(POINTS-1)] + $urandom_range(8) - 4;
			end else begin
				v = $urandom_range(22'h3FFFFF);
			end
			volts_to_send.push_back(VOLT_W'(v));
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (volts_to_send.size() != 0 || start || temps_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (!failed && temps_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// driver: hold start while busy, otherwise offer the next voltage or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && busy)) begin
			if (start)
				temps_due.push_back(convert_voltage(voltage_uv));
			if (volts_to_send.size() != 0 &&
			    ((sent_count >= CALM_FIRST && sent_count < CALM_LAST) ||
			     $urandom_range(99) >= IDLE_PCT)) begin
				start      <= 1'b1;
				voltage_uv <= volts_to_send.pop_front();
				sent_count <= sent_count + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every done pulse is one result transfer
	always @(posedge clk) begin
		reading_t due;
		if (arst_n && done) begin
			if (temps_due.size() == 0) begin
				$display("%0t: unexpected result temp_centi %0d out_of_range %0b",
				         $time, $signed(temp_centi), out_of_range);
				failed = 1'b1;
			end else begin
				due = temps_due.pop_front();
				if (temp_centi !== due.temp) begin
					$display("%0t: voltage %0d temp_centi expected %0d actual %0d",
					         $time, due.volts, $signed(due.temp), $signed(temp_centi));
					failed = 1'b1;
				end
				if (out_of_range !== due.oor) begin
					$display("%0t: voltage %0d out_of_range expected %0b actual %0b",
					         $time, due.volts, due.oor, out_of_range);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

endmodule
